// ===== hdl/nd_window_address_generator_macros.svh =====
`ifndef ND_WINDOW_ADDRESS_GENERATOR_MACROS_SVH
`define ND_WINDOW_ADDRESS_GENERATOR_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define NDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Asserts that a condition never holds.
`define NDW_ASSERT_NEVER(lbl, expr, msg) `NDW_ASSERT(lbl, !(expr), msg)

`endif

// ===== hdl/ndwag_pkg.sv =====
`default_nettype none

package ndwag_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned EB_W       = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTENTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BEG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SZ  = 2'd3;

  localparam logic [DATA_W-1:0] EXTENTS_RST = 64'h0001_0001_0001_0001;
  localparam logic [EB_W-1:0]   ELEM_SZ_RST = 9'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic restart;
    logic do_lo;
    logic do_hi;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic exhausted;
    logic last_step;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/ndwag_ctrl.sv =====
`default_nettype none

module ndwag_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               restart_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  ndwag_pkg::sts_t   sts_i,
  output ndwag_pkg::cmd_t   cmd_o
);
  import ndwag_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ovalid_d   = ovalid_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.restart = restart_i;
          if (restart_i || !sts_i.exhausted) begin
            state_d = ST_MUL_LO;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_MUL_LO: begin
        cmd_o.do_lo = 1'b1;
        state_d     = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.do_hi = 1'b1;
        if (sts_i.last_step) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_MUL_LO;
        end
      end
      ST_FINISH: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

// ===== hdl/ndwag_datapath.sv =====
`default_nettype none

module ndwag_datapath #(
  parameter int unsigned MAX_DIMS   = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire [ndwag_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [ndwag_pkg::DATA_W-1:0]            cfg_data_i,
  input  ndwag_pkg::cmd_t                        cmd_i,
  output ndwag_pkg::sts_t                        sts_o,
  output logic [ndwag_pkg::DATA_W-1:0]           offset_o,
  output logic                                   last_o,
  output logic                                   done_o
);
  import ndwag_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_DIMS + 1);
  localparam int unsigned DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [DATA_W-1:0] ext_q, beg_q, end_q;
  logic [EB_W-1:0]   eb_q;

  logic [COORD_BITS-1:0] ext_w [MAX_DIMS];
  logic [COORD_BITS-1:0] beg_w [MAX_DIMS];
  logic [COORD_BITS-1:0] end_w [MAX_DIMS];

  logic [COORD_BITS-1:0] pos_q [MAX_DIMS];
  logic [COORD_BITS-1:0] pos_nx [MAX_DIMS];
  logic                  exh_q;
  logic                  wrap_all;
  logic                  is_last;

  logic [CNT_W-1:0]    k_q;
  logic [DIM_IW-1:0]   k_idx;
  logic                k_in_dims;
  logic [DATA_W-1:0]   acc_q;
  logic [DATA_W-1:0]   lo_q;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [DATA_W-1:0]   prod;
  logic [DATA_W-1:0]   addend;

  logic [DATA_W-1:0] offset_q;
  logic              last_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= EXTENTS_RST;
      beg_q <= '0;
      end_q <= '0;
      eb_q  <= ELEM_SZ_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EXTENTS: ext_q <= cfg_data_i;
        CFG_WIN_BEG: beg_q <= cfg_data_i;
        CFG_WIN_END: end_q <= cfg_data_i;
        CFG_ELEM_SZ: eb_q  <= cfg_data_i[EB_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_field
    localparam int unsigned SH = (MAX_DIMS - 1 - g) * COORD_BITS;
    if (SH >= DATA_W) begin : g_zero
      assign ext_w[g] = '0;
      assign beg_w[g] = '0;
      assign end_w[g] = '0;
    end else begin : g_sel
      logic [DATA_W-1:0] ext_sh, beg_sh, end_sh;
      assign ext_sh   = ext_q >> SH;
      assign beg_sh   = beg_q >> SH;
      assign end_sh   = end_q >> SH;
      assign ext_w[g] = ext_sh[COORD_BITS-1:0];
      assign beg_w[g] = beg_sh[COORD_BITS-1:0];
      assign end_w[g] = end_sh[COORD_BITS-1:0];
    end
  end

  always_comb begin
    logic carry;
    carry   = 1'b1;
    is_last = 1'b1;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      if (pos_q[i] < end_w[i]) begin
        is_last = 1'b0;
      end
      if (carry) begin
        if (pos_q[i] < end_w[i]) begin
          pos_nx[i] = pos_q[i] + COORD_BITS'(1);
          carry     = 1'b0;
        end else begin
          pos_nx[i] = beg_w[i];
        end
      end else begin
        pos_nx[i] = pos_q[i];
      end
    end
    wrap_all = carry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_q[i] <= '0;
      end
      exh_q <= 1'b0;
    end else if (cmd_i.accept && cmd_i.restart) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_q[i] <= beg_w[i];
      end
      exh_q <= 1'b0;
    end else if (cmd_i.finish && !exh_q) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_q[i] <= pos_nx[i];
      end
      exh_q <= wrap_all;
    end
  end

  // Horner form: acc = acc * extent[k] + pos[k] per dimension, then one
  // final pass multiplies by the element size. Each pass runs the shared
  // 32x32 multiplier twice, low half of acc first.
  assign k_in_dims = (k_q < CNT_W'(MAX_DIMS));
  assign k_idx     = k_q[DIM_IW-1:0];

  always_comb begin
    if (k_in_dims) begin
      mul_b  = HALF_W'(ext_w[k_idx]);
      addend = DATA_W'(pos_q[k_idx]);
    end else begin
      mul_b  = HALF_W'(eb_q);
      addend = '0;
    end
    mul_a = cmd_i.do_hi ? acc_q[DATA_W-1:HALF_W] : acc_q[HALF_W-1:0];
    prod  = DATA_W'(mul_a) * DATA_W'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.accept) begin
      k_q <= '0;
    end else if (cmd_i.do_hi && !sts_o.last_step) begin
      k_q <= k_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= '0;
    end else if (cmd_i.do_hi) begin
      acc_q <= lo_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}} + addend;
    end
    if (cmd_i.do_lo) begin
      lo_q <= prod;
    end
    if (cmd_i.finish) begin
      offset_q <= exh_q ? '0 : acc_q;
      last_q   <= is_last && !exh_q;
      done_q   <= exh_q;
    end
  end

  assign sts_o.exhausted = exh_q;
  assign sts_o.last_step = (k_q == CNT_W'(MAX_DIMS));
  assign offset_o        = offset_q;
  assign last_o          = last_q;
  assign done_o          = done_q;

endmodule

`default_nettype wire

// ===== hdl/nd_window_address_generator.sv =====
// A walking item passes a low and a high multiply state for each dimension and for the
// element size, on the single shared 32x32 multiplier; an exhausted-window item skips
// them. Both register their result in the finish state, which waits while the output
// holds an untaken result. A new item is taken only in idle, once the last one's is registered.
// Reset (asynchronous, active low) restores the register reset values, puts the
// position at zero in every dimension and clears the exhausted flag.
`default_nettype none

module nd_window_address_generator #(
  parameter int unsigned MAX_DIMS   = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire [ndwag_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [0] restart
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [ndwag_pkg::DATA_W-1:0]         m_axis_tdata,   // [63:0] byte_offset
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser,   // [0] done_res
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [ndwag_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [ndwag_pkg::DATA_W-1:0]          cfg_data_i
);
  import ndwag_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ndwag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ndwag_datapath #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .offset_o    (m_axis_tdata),
    .last_o      (m_axis_tlast),
    .done_o      (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/nd_window_address_generator_checker.sv =====
`default_nettype none
`include "nd_window_address_generator_macros.svh"

module nd_window_address_generator_checker (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  s_axis_tvalid,
  input wire                                  s_axis_tready,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [ndwag_pkg::DATA_W-1:0]          m_axis_tdata,
  input wire                                  m_axis_tlast,
  input wire                                  m_axis_tuser
);

  `NDW_ASSERT_NEVER(a_last_done, m_axis_tvalid && m_axis_tlast && m_axis_tuser, "last and done")
  `NDW_ASSERT(a_done_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "done nonzero")
  `NDW_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input busy")
  `NDW_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "beat dropped")
  `NDW_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "beat changed")

endmodule

bind nd_window_address_generator nd_window_address_generator_checker u_checker (.*);

`default_nettype wire
